@@ hdl/vtpg_pkg.sv @@
// Shared types, constants and lookup functions for the test pattern generator.
// No dependencies; imported by every module of the block.
package vtpg_pkg;

    localparam int SPAN_W  = 13;     // width/height register width
    localparam int COORD_W = 12;
    localparam int FRAME_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int RAMP_N_W = 20;    // coordinate times 255
    localparam int RAMP_STEPS = 8;   // one quotient bit per stage
    localparam int BCD_W = 16;       // last four decimal digits
    localparam int BCD_BITS_PER_STAGE = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // floor(x/7) == (x * RECIP7) >> RECIP7_SHIFT for any 13-bit x
    localparam logic [14:0] RECIP7 = 15'd18725;
    localparam int RECIP7_SHIFT = 17;

    localparam logic [7:0] WHITE_LEVEL = 8'd235;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_U = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_V = 3'd5;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam logic [1:0] PAT_SOLID    = 2'd0;
    localparam logic [1:0] PAT_BARS     = 2'd1;
    localparam logic [1:0] PAT_GRADIENT = 2'd2;
    localparam logic [1:0] PAT_COUNTER  = 2'd3;

    typedef struct packed {
        logic [1:0]          plane;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic                oob;
        logic                cnt_ok;
        logic [RAMP_N_W-1:0] ramp_rem;
        logic [SPAN_W-1:0]   ramp_div;
        logic [7:0]          ramp_q;
        logic [15:0]         bar_rem;
        logic [SPAN_W-1:0]   bar_bw;
        logic                bar_sat;
        logic [2:0]          bar_q;
        logic [BCD_W-1:0]    bcd;
        logic [FRAME_W-1:0]  frame;
    } vtpg_item_t;

    function automatic logic [7:0] bar_luma(input logic [2:0] b);
        case (b)
            3'd0: bar_luma = 8'd235;
            3'd1: bar_luma = 8'd219;
            3'd2: bar_luma = 8'd188;
            3'd3: bar_luma = 8'd173;
            3'd4: bar_luma = 8'd145;
            3'd5: bar_luma = 8'd113;
            default: bar_luma = 8'd16;
        endcase
    endfunction

    function automatic logic [7:0] bar_cb(input logic [2:0] b);
        case (b)
            3'd0: bar_cb = 8'd128;
            3'd1, 3'd2, 3'd3: bar_cb = 8'd0;
            3'd4, 3'd5: bar_cb = 8'd255;
            default: bar_cb = 8'd128;
        endcase
    endfunction

    function automatic logic [7:0] bar_cr(input logic [2:0] b);
        case (b)
            3'd0: bar_cr = 8'd128;
            3'd1: bar_cr = 8'd0;
            3'd2: bar_cr = 8'd255;
            3'd3: bar_cr = 8'd0;
            3'd4: bar_cr = 8'd255;
            3'd5: bar_cr = 8'd0;
            default: bar_cr = 8'd128;
        endcase
    endfunction

    function automatic logic [7:0] font_row(input logic [3:0] d, input logic [2:0] r);
        logic [63:0] g;
        case (d)
            4'd0: g = 64'h3E63737B6F673E00;
            4'd1: g = 64'h183818181818_7E00;
            4'd2: g = 64'h3E63030E1C387F00;
            4'd3: g = 64'h3E63031C03633E00;
            4'd4: g = 64'h060E1E36667F0600;
            4'd5: g = 64'h7F7F607E03633E00;
            4'd6: g = 64'h1C30607E63633E00;
            4'd7: g = 64'h7F6303060C181800;
            4'd8: g = 64'h3E63633E63633E00;
            4'd9: g = 64'h3E63633F03063800;
            default: g = 64'h0;
        endcase
        font_row = g[8*(7-r) +: 8];
    endfunction

endpackage

@@ hdl/vtpg_entry.sv @@
// Input stage: plane geometry, bounds check and divider setup.
// Depends on vtpg_pkg.
module vtpg_entry #(
    parameter int MAX_WIDTH  = vtpg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = vtpg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    plane_select,
    input  logic [vtpg_pkg::COORD_W-1:0]  column,
    input  logic [vtpg_pkg::COORD_W-1:0]  line,
    input  logic [vtpg_pkg::FRAME_W-1:0]  frame_number,
    input  logic [vtpg_pkg::SPAN_W-1:0]   frame_width,
    input  logic [vtpg_pkg::SPAN_W-1:0]   frame_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vtpg_pkg::vtpg_item_t          out_item
);
    import vtpg_pkg::*;

    localparam logic [SPAN_W-1:0] WMAX =
        (MAX_WIDTH > 8191) ? 13'd8191 : SPAN_W'(MAX_WIDTH);
    localparam logic [SPAN_W-1:0] HMAX =
        (MAX_HEIGHT > 8191) ? 13'd8191 : SPAN_W'(MAX_HEIGHT);

    logic              valid_reg, valid_next;
    vtpg_item_t        item_reg, item_next;
    logic [SPAN_W-1:0] w, h, pw, ph, rspan, bw_raw;
    logic [COORD_W-1:0] rpos;
    logic [27:0]       bw_prod;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        w = (frame_width > WMAX) ? WMAX : frame_width;
        h = (frame_height > HMAX) ? HMAX : frame_height;
        pw = (plane_select == PLANE_Y) ? w : {1'b0, w[SPAN_W-1:1]};
        ph = (plane_select == PLANE_Y) ? h : {1'b0, h[SPAN_W-1:1]};
        rpos = (plane_select == PLANE_V) ? line : column;
        rspan = (plane_select == PLANE_V) ? ph : pw;
        bw_prod = 28'(pw) * 28'(RECIP7);
        bw_raw = SPAN_W'(bw_prod >> RECIP7_SHIFT);

        item_next = '0;
        item_next.plane = plane_select;
        item_next.col = column;
        item_next.row = line;
        item_next.oob = (plane_select > PLANE_V) || ({1'b0, column} >= pw)
                        || ({1'b0, line} >= ph);
        item_next.cnt_ok = (w >= 13'd32) && (h >= 13'd8) && (column < 12'd64)
                           && (line < 12'd16) && (plane_select == PLANE_Y);
        item_next.ramp_rem = {rpos, 8'd0} - {8'd0, rpos};
        item_next.ramp_div = (rspan > 13'd1) ? rspan - 13'd1 : 13'd1;
        item_next.bar_rem = {4'd0, column};
        item_next.bar_bw = (bw_raw == '0) ? 13'd1 : bw_raw;
        item_next.frame = frame_number;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

@@ hdl/vtpg_stage.sv @@
// One divider/BCD stage: a ramp quotient bit, a bar index step in stages 0-3 and
// four double-dabble shifts of the frame number. Depends on vtpg_pkg.
module vtpg_stage #(
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vtpg_pkg::vtpg_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vtpg_pkg::vtpg_item_t out_item
);
    import vtpg_pkg::*;

    localparam int RBIT = RAMP_STEPS - 1 - IDX;
    // bar quotient bit handled here; only stages one to three use it
    localparam int QBIT = (IDX >= 1 && IDX <= 3) ? 3 - IDX : 0;

    logic        valid_reg, valid_next;
    vtpg_item_t  item_reg, item_next;
    logic [RAMP_N_W:0] rdiv;
    logic [15:0] bdiv;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next = in_item;
        // ramp: restoring division, quotient bit RBIT
        rdiv = (RAMP_N_W + 1)'(in_item.ramp_div) << RBIT;
        if ({1'b0, in_item.ramp_rem} >= rdiv) begin
            item_next.ramp_rem = in_item.ramp_rem - rdiv[RAMP_N_W-1:0];
            item_next.ramp_q[RBIT] = 1'b1;
        end
        // bars: saturation check, then three quotient bits
        bdiv = 16'(in_item.bar_bw);
        if (IDX == 0) begin
            item_next.bar_sat = in_item.bar_rem >= ((bdiv << 3) - bdiv);
        end else if (IDX <= 3) begin
            bdiv = bdiv << QBIT;
            if (in_item.bar_rem >= bdiv) begin
                item_next.bar_rem = in_item.bar_rem - bdiv;
                item_next.bar_q[QBIT] = 1'b1;
            end
        end
        // keep only the low four BCD digits; carries only move upward
        for (int j = 0; j < BCD_BITS_PER_STAGE; j++) begin
            for (int k = 0; k < 4; k++) begin
                if (item_next.bcd[4*k +: 4] >= 4'd5)
                    item_next.bcd[4*k +: 4] = item_next.bcd[4*k +: 4] + 4'd3;
            end
            item_next.bcd = {item_next.bcd[BCD_W-2:0], item_next.frame[FRAME_W-1]};
            item_next.frame = {item_next.frame[FRAME_W-2:0], 1'b0};
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

@@ hdl/vtpg_out.sv @@
// Output stage: pattern select, counter overlay and result register.
// Depends on vtpg_pkg.
module vtpg_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vtpg_pkg::vtpg_item_t in_item,
    input  logic [1:0]           pattern_select,
    input  logic [7:0]           solid_luma,
    input  logic [7:0]           solid_cb,
    input  logic [7:0]           solid_cr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           sample_value,
    output logic                 out_of_plane
);
    import vtpg_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] sample_reg, sample_next;
    logic       oob_reg;
    logic [2:0] bidx;
    logic [3:0] digit;
    logic [7:0] glyph;
    logic       lit;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        bidx = in_item.bar_sat ? 3'd6 : in_item.bar_q;
        case (in_item.col[5:4])
            2'd0: digit = in_item.bcd[15:12];
            2'd1: digit = in_item.bcd[11:8];
            2'd2: digit = in_item.bcd[7:4];
            default: digit = in_item.bcd[3:0];
        endcase
        glyph = font_row(digit, in_item.row[3:1]);
        lit = in_item.cnt_ok && glyph[3'd7 - in_item.col[3:1]];

        case (pattern_select)
            PAT_SOLID:
                sample_next = (in_item.plane == PLANE_Y) ? solid_luma :
                              (in_item.plane == PLANE_U) ? solid_cb : solid_cr;
            PAT_BARS:
                sample_next = (in_item.plane == PLANE_Y) ? bar_luma(bidx) :
                              (in_item.plane == PLANE_U) ? bar_cb(bidx) : bar_cr(bidx);
            default:
                sample_next = (pattern_select == PAT_COUNTER && lit) ? WHITE_LEVEL
                                                                     : in_item.ramp_q;
        endcase
        if (in_item.oob) sample_next = 8'd0;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            sample_reg <= sample_next;
            oob_reg <= in_item.oob;
        end
    end

    assign out_valid = valid_reg;
    assign sample_value = sample_reg;
    assign out_of_plane = oob_reg;

endmodule

@@ hdl/video_test_pattern_generator.sv @@
// YUV420 test pattern sample source, one sample per transaction.
// Each transaction passes through the entry register, 8 divider/BCD stages and the
// output register; throughput one transaction per cycle while m_ready is not held low.
// The 8 stages carry one ramp quotient bit and four BCD shifts each.
// Synchronous active-low reset clears all valid bits and the configuration registers; data registers are not reset.
module video_test_pattern_generator #(
    parameter int MAX_WIDTH  = vtpg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = vtpg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_plane_select,
    input  logic [vtpg_pkg::COORD_W-1:0]      s_column,
    input  logic [vtpg_pkg::COORD_W-1:0]      s_line,
    input  logic [vtpg_pkg::FRAME_W-1:0]      s_frame_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_sample_value,
    output logic                              m_out_of_plane
);
    import vtpg_pkg::*;

    logic [1:0]        pattern_reg;
    logic [SPAN_W-1:0] width_reg, height_reg;
    logic [7:0]        solid_y_reg, solid_u_reg, solid_v_reg;

    logic       v   [RAMP_STEPS+1];
    logic       r   [RAMP_STEPS+1];
    vtpg_item_t it  [RAMP_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PAT_SOLID;
            width_reg   <= 13'd640;
            height_reg  <= 13'd480;
            solid_y_reg <= 8'd16;
            solid_u_reg <= 8'd128;
            solid_v_reg <= 8'd128;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN: pattern_reg <= cfg_wdata[1:0];
                REG_WIDTH:   width_reg   <= cfg_wdata;
                REG_HEIGHT:  height_reg  <= cfg_wdata;
                REG_SOLID_Y: solid_y_reg <= cfg_wdata[7:0];
                REG_SOLID_U: solid_u_reg <= cfg_wdata[7:0];
                REG_SOLID_V: solid_v_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    vtpg_entry #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_entry (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .plane_select(s_plane_select), .column(s_column), .line(s_line),
        .frame_number(s_frame_number),
        .frame_width(width_reg), .frame_height(height_reg),
        .out_valid(v[0]), .out_ready(r[0]), .out_item(it[0])
    );

    for (genvar g = 0; g < RAMP_STEPS; g++) begin : g_stage
        vtpg_stage #(.IDX(g)) u_stage (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(v[g]), .in_ready(r[g]), .in_item(it[g]),
            .out_valid(v[g+1]), .out_ready(r[g+1]), .out_item(it[g+1])
        );
    end

    vtpg_out u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v[RAMP_STEPS]), .in_ready(r[RAMP_STEPS]), .in_item(it[RAMP_STEPS]),
        .pattern_select(pattern_reg),
        .solid_luma(solid_y_reg), .solid_cb(solid_u_reg), .solid_cr(solid_v_reg),
        .out_valid(m_valid), .out_ready(m_ready),
        .sample_value(m_sample_value), .out_of_plane(m_out_of_plane)
    );

`ifndef SYNTH
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_plane |-> m_sample_value == 8'd0)
        else $error("out-of-plane result with nonzero sample");
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage empty");
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for video_test_pattern_generator.
// Depends on vtpg_pkg and the block; predicts every sample and compares in order.
module tb;
    import vtpg_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_plane_select = '0;
    logic [COORD_W-1:0]    s_column = '0;
    logic [COORD_W-1:0]    s_line = '0;
    logic [FRAME_W-1:0]    s_frame_number = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_sample_value;
    logic                  m_out_of_plane;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 40;

    video_test_pattern_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_plane_select(s_plane_select), .s_column(s_column), .s_line(s_line),
        .s_frame_number(s_frame_number),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_value(m_sample_value), .m_out_of_plane(m_out_of_plane)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] sample;
        logic       oob;
    } sample_t;

    // shadow of the block's registers
    logic [1:0]  pat_sel;
    logic [12:0] fr_w, fr_h;
    logic [7:0]  sol_y, sol_u, sol_v;

    sample_t expected_samples[$];
    int      mismatches = 0;
    bit      failed = 0;
    int      idle_cycles = 0;
    bit      rx_hold = 0;

    function automatic logic [7:0] glyph_row(int d, int r);
        logic [63:0] g;
        case (d)
            0: g = 64'h3E63737B6F673E00;
            1: g = 64'h1838181818187E00;
            2: g = 64'h3E63030E1C387F00;
            3: g = 64'h3E63031C03633E00;
            4: g = 64'h060E1E36667F0600;
            5: g = 64'h7F7F607E03633E00;
            6: g = 64'h1C30607E63633E00;
            7: g = 64'h7F6303060C181800;
            8: g = 64'h3E63633E63633E00;
            default: g = 64'h3E63633F03063800;
        endcase
        return g[8*(7-r) +: 8];
    endfunction

    function automatic sample_t pattern_sample(logic [1:0] pl, int unsigned col,
                                               int unsigned row, logic [31:0] frame);
        int unsigned w, h, pw, ph, bw, b, dv, val, d;
        sample_t r;
        logic [7:0] gr;
        logic [7:0] by[7] = '{235, 219, 188, 173, 145, 113, 16};
        logic [7:0] bu[7] = '{128, 0, 0, 0, 255, 255, 128};
        logic [7:0] bv[7] = '{128, 0, 255, 0, 255, 0, 128};
        w = fr_w > 4096 ? 4096 : fr_w;
        h = fr_h > 4096 ? 4096 : fr_h;
        pw = pl == PLANE_Y ? w : w / 2;
        ph = pl == PLANE_Y ? h : h / 2;
        r = '{sample: 8'd0, oob: 1'b1};
        if (pl > PLANE_V || col >= pw || row >= ph) return r;
        case (pat_sel)
            PAT_SOLID: val = pl == PLANE_Y ? sol_y : (pl == PLANE_U ? sol_u : sol_v);
            PAT_BARS: begin
                bw = pw / 7;
                if (bw == 0) bw = 1;
                b = col / bw;
                if (b > 6) b = 6;
                val = pl == PLANE_Y ? by[b] : (pl == PLANE_U ? bu[b] : bv[b]);
            end
            default: begin
                if (pl == PLANE_V) begin
                    dv = ph > 1 ? ph - 1 : 1;
                    val = ((row * 255) / dv) & 8'hFF;
                end else begin
                    dv = pw > 1 ? pw - 1 : 1;
                    val = ((col * 255) / dv) & 8'hFF;
                end
                if (pat_sel == PAT_COUNTER && pl == PLANE_Y && w >= 32 && h >= 8
                    && col < 64 && row < 16) begin
                    d = frame;
                    for (int k = col / 16; k < 3; k++) d = d / 10;
                    d = d % 10;
                    gr = glyph_row(d, row / 2);
                    if (gr[7 - (col % 16) / 2]) val = WHITE_LEVEL;
                end
            end
        endcase
        r.sample = val[7:0];
        r.oob = 1'b0;
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PATTERN: pat_sel = v[1:0];
            REG_WIDTH:   fr_w = v;
            REG_HEIGHT:  fr_h = v;
            REG_SOLID_Y: sol_y = v[7:0];
            REG_SOLID_U: sol_u = v[7:0];
            default:     sol_v = v[7:0];
        endcase
    endtask

    task automatic set_config(logic [1:0] p, logic [12:0] w, logic [12:0] h,
                              logic [7:0] y, logic [7:0] u, logic [7:0] v);
        wait (expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_PATTERN, p);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SOLID_Y, y);
        write_reg(REG_SOLID_U, u);
        write_reg(REG_SOLID_V, v);
    endtask

    // drive one request and hold it until the transaction completes
    task automatic send_sample(logic [1:0] pl, logic [11:0] col, logic [11:0] row,
                               logic [31:0] frame);
        s_valid <= 1'b1;
        s_plane_select <= pl;
        s_column <= col;
        s_line <= row;
        s_frame_number <= frame;
        expected_samples.push_back(pattern_sample(pl, col, row, frame));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_random(int n, int unsigned cmax, int unsigned rmax);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 5));
            end
            burst--;
            if ($urandom_range(0, 15) == 0)
                send_sample($urandom_range(0, 3), $urandom, $urandom, $urandom);
            else
                send_sample($urandom_range(0, 3), $urandom_range(0, cmax),
                            $urandom_range(0, rmax), $urandom);
        end
        idle_sender(0);
    endtask

    task automatic test_reset_defaults();
        pat_sel = PAT_SOLID; fr_w = 640; fr_h = 480;
        sol_y = 16; sol_u = 128; sol_v = 128;
        send_sample(PLANE_Y, 0, 0, 0);
        send_sample(PLANE_U, 319, 239, 0);
        send_sample(PLANE_V, 320, 0, 0);
        idle_sender(0);
    endtask

    task automatic test_directed();
        set_config(PAT_SOLID, 13'h1FFF, 13'h1FFF, 8'hFF, 8'h00, 8'hAA);
        send_sample(PLANE_Y, 12'hFFF, 12'hFFF, 32'hFFFFFFFF);
        send_sample(PLANE_U, 12'd2047, 12'd2047, 0);
        send_sample(PLANE_V, 12'd2048, 0, 0);
        send_sample(2'd3, 0, 0, 0);
        idle_sender(0);
        set_config(PAT_BARS, 13'd1, 13'd1, 0, 0, 0);
        send_sample(PLANE_Y, 0, 0, 0);
        send_sample(PLANE_U, 0, 0, 0);
        idle_sender(0);
        set_config(PAT_BARS, 13'd20, 13'd4, 0, 0, 0);
        for (int c = 0; c < 20; c += 3) send_sample(PLANE_Y, c, 1, 0);
        send_sample(PLANE_V, 9, 1, 0);
        idle_sender(0);
        set_config(PAT_GRADIENT, 13'd2, 13'd2, 0, 0, 0);
        send_sample(PLANE_U, 0, 0, 0);
        send_sample(PLANE_V, 0, 0, 0);
        send_sample(PLANE_Y, 1, 1, 0);
        idle_sender(0);
        set_config(PAT_COUNTER, 13'd0, 13'd0, 0, 0, 0);
        send_sample(PLANE_Y, 0, 0, 0);
        idle_sender(0);
    endtask

    task automatic test_frame_counter();
        set_config(PAT_COUNTER, 13'd64, 13'd16, 0, 0, 0);
        for (int i = 0; i < 200; i++)
            send_sample(PLANE_Y, $urandom_range(0, 63), $urandom_range(0, 15),
                        $urandom_range(0, 9999) + 10000 * $urandom_range(0, 3));
        idle_sender(0);
        set_config(PAT_COUNTER, 13'd31, 13'd100, 0, 0, 0);
        send_random(50, 40, 20);
        set_config(PAT_COUNTER, 13'd100, 13'd7, 0, 0, 0);
        send_random(50, 70, 10);
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 12; ph++) begin
            set_config($urandom_range(0, 3), $urandom_range(1, 300), $urandom_range(1, 300),
                       $urandom, $urandom, $urandom);
            send_random(120, 320, 320);
        end
        set_config(PAT_COUNTER, 13'd4096, 13'd4096, 0, 0, 0);
        send_random(100, 4095, 4095);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_config(PAT_GRADIENT, 13'd200, 13'd200, 0, 0, 0);
        rx_hold = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                rx_hold = 0;
            end
            send_random(150, 199, 199);
        join
    endtask

    always @(posedge aclk) begin
        if (!aresetn || rx_hold) m_ready <= 1'b0;
        else if ($urandom_range(0, 63) < 16) m_ready <= ($urandom_range(0, 2) == 0);
        else if ($urandom_range(0, 63) == 0) m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        sample_t exp_s;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: value %0d oob %0b",
                                               m_sample_value, m_out_of_plane);
            end else begin
                exp_s = expected_samples.pop_front();
                if (m_sample_value !== exp_s.sample || m_out_of_plane !== exp_s.oob) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %0d oob %0b, got %0d oob %0b",
                                 exp_s.sample, exp_s.oob, m_sample_value, m_out_of_plane);
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_frame_counter();
        test_backpressure();
        test_random_configs();
        wait (expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

    initial begin
        wait (idle_cycles >= TIMEOUT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end
endmodule
